[hdl/gmps_pkg.sv]
package gmps_pkg;

	localparam int SUM_W     = 16;
	localparam int CNT_W     = 30;
	localparam int DIGIT_W   = 4;
	localparam int CFG_W     = 8;
	localparam int OUT_SUM_W = 12;

	localparam logic [CNT_W-1:0]     COUNT_MOD   = 30'd1000000007;
	localparam logic [DIGIT_W-1:0]   DIGIT_LIMIT = 4'd9;
	localparam logic [CFG_W-1:0]     SIDE_RESET  = 8'd128;
	localparam logic [OUT_SUM_W-1:0] SUM_LIMIT   = 12'hFFF;

	// reachable mark, best sum and best-path count of one cell
	typedef struct packed {
		logic             reach;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	// per-cell control flags carried with the cell
	typedef struct packed {
		logic is_start;
		logic is_end;
		logic first_row;
		logic first_col;
		logic blocked;
	} cell_ctl_t;

endpackage

[hdl/gmps_if.sv]
interface gmps_cell_if;
	logic       valid;
	logic       ready;
	logic [3:0] cell_digit;
	logic       blocked;

	modport source (output valid, cell_digit, blocked, input ready);
	modport sink (input valid, cell_digit, blocked, output ready);
endinterface

interface gmps_result_if;
	logic        valid;
	logic        ready;
	logic [11:0] best_sum;
	logic [29:0] path_count;

	modport source (output valid, best_sum, path_count, input ready);
	modport sink (input valid, best_sum, path_count, output ready);
endinterface

[hdl/gmps_line_store.sv]
module gmps_line_store #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output gmps_pkg::entry_t     rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  gmps_pkg::entry_t     wr_data
);
	import gmps_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hdl/gmps_cell_merge.sv]
module gmps_cell_merge (
	input  gmps_pkg::cell_ctl_t          ctl,
	input  logic [gmps_pkg::DIGIT_W-1:0] value,
	input  gmps_pkg::entry_t             right,
	input  gmps_pkg::entry_t             below,
	input  gmps_pkg::entry_t             diag,
	output gmps_pkg::entry_t             below_m,
	output gmps_pkg::entry_t             cur
);
	import gmps_pkg::*;

	localparam int TW = CNT_W + 2;
	localparam logic [TW-1:0] MOD_T  = {2'b00, COUNT_MOD};
	localparam logic [TW-1:0] MOD2_T = {2'b00, COUNT_MOD} << 1;

	entry_t           right_m;
	entry_t           diag_m;
	logic             any;
	logic [SUM_W-1:0] best;
	logic [TW-1:0]    total;

	always_comb begin
		// missing neighbours at the bottom row and right column
		right_m = ctl.first_col ? '0 : right;
		below_m = ctl.first_row ? '0 : below;
		diag_m  = (ctl.first_row || ctl.first_col) ? '0 : diag;

		any  = right_m.reach || below_m.reach || diag_m.reach;
		best = '0;
		if (right_m.reach && right_m.sum > best) begin
			best = right_m.sum;
		end
		if (below_m.reach && below_m.sum > best) begin
			best = below_m.sum;
		end
		if (diag_m.reach && diag_m.sum > best) begin
			best = diag_m.sum;
		end

		// counts are each below the modulus, so the sum stays under three times it
		total = '0;
		if (right_m.reach && right_m.sum == best) begin
			total = total + {2'b00, right_m.cnt};
		end
		if (below_m.reach && below_m.sum == best) begin
			total = total + {2'b00, below_m.cnt};
		end
		if (diag_m.reach && diag_m.sum == best) begin
			total = total + {2'b00, diag_m.cnt};
		end
		if (total >= MOD2_T) begin
			total = total - MOD2_T;
		end else if (total >= MOD_T) begin
			total = total - MOD_T;
		end

		cur = '0;
		if (ctl.is_start) begin
			cur.reach = 1'b1;
			cur.cnt   = CNT_W'(1);
		end else if (!(ctl.blocked && !ctl.is_end) && any) begin
			cur.reach = 1'b1;
			cur.sum   = best + SUM_W'(value);
			cur.cnt   = total[CNT_W-1:0];
		end
	end

endmodule

[hdl/grid_max_path_sum_counter.sv]
// grid maximum path sum and best-path counter
//
// cells of a square grid arrive on cell_in in reverse raster order: the
// bottom-right start cell first, right to left within a row, rows bottom to
// top, the top-left end cell last. one request per cell, valid/ready.
// after the end cell one request leaves on result_out with the best digit
// sum (saturated at 4095) and the number of best paths mod 1000000007, or
// both zero when the end cannot be reached.
// throughput: one cell per cycle unless the end cell waits on a held result,
// set by the single merge stage and the one-read one-write line store of the row below.
// an accepted cell is merged in the cycle after it is taken; the end cell's
// result is registered into the result register when it leaves the merge stage.
// side_length is written through cfg_wr_en/cfg_wr_data; the user must write it only
// while idle, which the block does not enforce; a write restarts the grid at the start cell.
// reset: side 128, grid restarted, no pending cell or result. the line store
// is not cleared; the bottom row ignores what it reads.
// a stalled receiver holds the result register; cells keep flowing until the
// next end cell needs that register.
module grid_max_path_sum_counter #(
	parameter int MAX_SIDE = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [gmps_pkg::CFG_W-1:0]  cfg_wr_data,
	gmps_cell_if.sink                   cell_in,
	gmps_result_if.source               result_out
);
	import gmps_pkg::*;

	localparam int PW = $clog2(MAX_SIDE);
	localparam int SW = ($clog2(MAX_SIDE + 1) > CFG_W) ? $clog2(MAX_SIDE + 1) : CFG_W;

	// configuration and grid position
	logic [CFG_W-1:0] side_q;
	logic [SW-1:0]    side_ext;
	logic [SW-1:0]    side_use;
	logic [PW-1:0]    last_pos;
	logic [PW-1:0]    row_q;
	logic [PW-1:0]    col_q;

	// front end decode of the incoming cell
	logic                 in_acc;
	cell_ctl_t            ctl_w;
	logic [DIGIT_W-1:0]   value_w;

	// merge stage
	logic                 valid_s1;
	cell_ctl_t            ctl_s1;
	logic [DIGIT_W-1:0]   value_s1;
	logic [PW-1:0]        col_s1;
	entry_t               below_s1;
	entry_t               below_m;
	entry_t               cur;
	entry_t               right_q;
	entry_t               diag_q;
	logic                 s1_adv;

	// result register
	logic                 out_valid_q;
	logic [OUT_SUM_W-1:0] out_sum_q;
	logic [CNT_W-1:0]     out_cnt_q;
	logic [OUT_SUM_W-1:0] out_sum_w;

	// side clamped to 2..MAX_SIDE
	always_comb begin
		side_ext = SW'(side_q);
		if (side_ext < SW'(2)) begin
			side_use = SW'(2);
		end else if (side_ext > SW'(MAX_SIDE)) begin
			side_use = SW'(MAX_SIDE);
		end else begin
			side_use = side_ext;
		end
		last_pos = PW'(side_use - SW'(1));
	end

	// the merge stage only waits when it holds the end cell and the result is stuck
	assign s1_adv        = valid_s1 && (!ctl_s1.is_end || !out_valid_q || result_out.ready);
	assign cell_in.ready = !valid_s1 || s1_adv;
	assign in_acc        = cell_in.valid && cell_in.ready;

	always_comb begin
		ctl_w.is_start  = (row_q == '0) && (col_q == '0);
		ctl_w.is_end    = (row_q == last_pos) && (col_q == last_pos);
		ctl_w.first_row = (row_q == '0);
		ctl_w.first_col = (col_q == '0);
		ctl_w.blocked   = cell_in.blocked;
		// digits above nine count as nine, start and end cells as zero
		if (ctl_w.is_start || ctl_w.is_end) begin
			value_w = '0;
		end else if (cell_in.cell_digit > DIGIT_LIMIT) begin
			value_w = DIGIT_LIMIT;
		end else begin
			value_w = cell_in.cell_digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RESET;
		end else if (cfg_wr_en) begin
			side_q <= cfg_wr_data;
		end
	end

	// position walks right to left, then up a row; wraps after the end cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_wr_en) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			if (ctl_w.is_end) begin
				row_q <= '0;
				col_q <= '0;
			end else if (col_q == last_pos) begin
				row_q <= row_q + PW'(1);
				col_q <= '0;
			end else begin
				col_q <= col_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ctl_s1   <= ctl_w;
			value_s1 <= value_w;
			col_s1   <= col_q;
		end
	end

	// entry of the row below is read when the cell is taken, written when it leaves
	gmps_line_store #(
		.DEPTH (MAX_SIDE),
		.AW    (PW)
	) u_line_store (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (col_q),
		.rd_data (below_s1),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (cur)
	);

	gmps_cell_merge u_cell_merge (
		.ctl     (ctl_s1),
		.value   (value_s1),
		.right   (right_q),
		.below   (below_s1),
		.diag    (diag_q),
		.below_m (below_m),
		.cur     (cur)
	);

	// right and diagonal neighbours; masked on the first column and row
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			right_q <= cur;
			diag_q  <= below_m;
		end
	end

	assign out_sum_w = (cur.sum > SUM_W'(SUM_LIMIT)) ? SUM_LIMIT : cur.sum[OUT_SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && ctl_s1.is_end) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && ctl_s1.is_end) begin
			out_sum_q <= out_sum_w;
			out_cnt_q <= cur.cnt;
		end
	end

	assign result_out.valid      = out_valid_q;
	assign result_out.best_sum   = out_sum_q;
	assign result_out.path_count = out_cnt_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && ctl_s1.is_end) |-> (!out_valid_q || result_out.ready))
		else $error("result register overwritten");

	a_wrap_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && ctl_w.is_end && !cfg_wr_en) |=> (row_q == '0 && col_q == '0))
		else $error("position did not wrap after end cell");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= last_pos) && (row_q <= last_pos))
		else $error("position outside grid");

	a_count_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && cur.reach) |-> (cur.cnt < COUNT_MOD))
		else $error("path count not reduced");

endmodule

[tb/gmps_path_checker.sv]
`timescale 1ns / 1ps

module gmps_path_checker #(
	parameter int MAX_SIDE = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [gmps_pkg::CFG_W-1:0] cfg_wr_data,
	gmps_cell_if                       cell_mon,
	gmps_result_if                     res_mon,
	output int                         pending,
	output int                         errors,
	output int                         results_seen
);
	import gmps_pkg::*;

	// wide sum so that saturation is seen by the comparison, not hidden
	typedef struct packed {
		logic             reach;
		logic [31:0]      sum;
		logic [CNT_W-1:0] cnt;
	} path_state_t;

	typedef struct packed {
		logic [OUT_SUM_W-1:0] best;
		logic [CNT_W-1:0]     count;
	} path_total_t;

	localparam path_state_t UNREACHED = '0;

	path_state_t      line_below [MAX_SIDE];
	path_state_t      right_cell;
	path_state_t      diag_cell;
	int unsigned      row_pos;
	int unsigned      col_pos;
	logic [CFG_W-1:0] side_reg;
	path_total_t      awaited_totals [$];

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: mismatch in %s: got %0d, want %0d", $time, what, got, want);
		errors++;
	endtask

	task automatic restart_walk();
		right_cell = UNREACHED;
		diag_cell  = UNREACHED;
		row_pos    = 0;
		col_pos    = 0;
	endtask

	function automatic path_state_t fold_in(path_state_t acc, path_state_t src,
			logic [31:0] value);
		logic [31:0]    cand;
		logic [CNT_W:0] total;
		if (!src.reach)
			return acc;
		cand = src.sum + value;
		if (!acc.reach || cand > acc.sum) begin
			acc.reach = 1'b1;
			acc.sum   = cand;
			acc.cnt   = src.cnt;
		end else if (cand == acc.sum) begin
			total = {1'b0, acc.cnt} + {1'b0, src.cnt};
			if (total >= {1'b0, COUNT_MOD})
				total = total - {1'b0, COUNT_MOD};
			acc.cnt = total[CNT_W-1:0];
		end
		return acc;
	endfunction

	// one cell of the reverse raster walk
	task automatic walk_cell(input logic [DIGIT_W-1:0] digit_in, input logic blk);
		int unsigned side;
		int unsigned r;
		int unsigned c;
		logic [31:0] value;
		logic        is_start;
		logic        is_end;
		path_state_t below;
		path_state_t diag;
		path_state_t right;
		path_state_t cur;
		path_total_t total;

		side = 32'(side_reg);
		if (side < 2)
			side = 2;
		if (side > MAX_SIDE)
			side = MAX_SIDE;
		if (row_pos >= side || col_pos >= side)
			restart_walk();
		r = row_pos;
		c = col_pos;

		is_start = (r == 0 && c == 0);
		is_end   = (r == side - 1 && c == side - 1);
		if (is_start || is_end)
			value = '0;
		else
			value = 32'((digit_in > DIGIT_LIMIT) ? DIGIT_LIMIT : digit_in);

		below = (r > 0) ? line_below[c] : UNREACHED;
		diag  = (r > 0 && c > 0) ? diag_cell : UNREACHED;
		right = (c > 0) ? right_cell : UNREACHED;

		cur = UNREACHED;
		if (is_start) begin
			cur.reach = 1'b1;
			cur.cnt   = CNT_W'(1);
		end else if (!(blk && !is_end)) begin
			cur = fold_in(cur, right, value);
			cur = fold_in(cur, below, value);
			cur = fold_in(cur, diag, value);
		end

		diag_cell     = below;
		line_below[c] = cur;
		right_cell    = cur;

		if (is_end) begin
			if (!cur.reach)
				total.best = '0;
			else if (cur.sum > SUM_LIMIT)
				total.best = SUM_LIMIT;
			else
				total.best = cur.sum[OUT_SUM_W-1:0];
			total.count = cur.reach ? cur.cnt : '0;
			awaited_totals.push_back(total);
			restart_walk();
		end else if (c + 1 >= side) begin
			col_pos    = 0;
			row_pos    = r + 1;
			right_cell = UNREACHED;
			diag_cell  = UNREACHED;
		end else begin
			col_pos = c + 1;
		end
	endtask

	initial begin
		errors       = 0;
		results_seen = 0;
		pending      = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		path_total_t oldest;
		if (!arst_n) begin
			for (int i = 0; i < MAX_SIDE; i++)
				line_below[i] = UNREACHED;
			side_reg = SIDE_RESET;
			restart_walk();
			awaited_totals.delete();
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				side_reg = cfg_wr_data;
				restart_walk();
			end
			if (cell_mon.valid && cell_mon.ready)
				walk_cell(cell_mon.cell_digit, cell_mon.blocked);
			if (res_mon.valid && res_mon.ready) begin
				results_seen++;
				if (awaited_totals.size() == 0) begin
					report_mismatch("result with none awaited, best_sum", res_mon.best_sum, 0);
				end else begin
					oldest = awaited_totals.pop_front();
					if (res_mon.best_sum !== oldest.best)
						report_mismatch("best_sum", res_mon.best_sum, oldest.best);
					if (res_mon.path_count !== oldest.count)
						report_mismatch("path_count", res_mon.path_count, oldest.count);
				end
			end
			pending <= awaited_totals.size();
		end
	end

endmodule

[tb/grid_max_path_sum_counter_tb.sv]
`timescale 1ns / 1ps

module grid_max_path_sum_counter_tb;
	import gmps_pkg::*;

	localparam int MAX_SIDE        = 128;
	localparam int LIMIT_CYCLES    = 2_000_000;
	localparam int ITEM_TARGET     = 800;
	localparam int RESULT_TARGET   = 24;
	localparam int HOLD_OFF_CYCLES = 400;
	// phase of the flat grid whose counts wrap; the random part runs at least this far
	localparam int LAST_BIG_PHASE  = 3;
	localparam logic [CFG_W-1:0] WRAP_SIDE = 8'd16;

	// how the digits of one grid are drawn
	typedef enum int {
		STYLE_MIXED,
		STYLE_FLAT,
		STYLE_HIGH,
		STYLE_BINARY
	} digit_style_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;

	gmps_cell_if   cell_if ();
	gmps_result_if result_if ();

	int mismatches;
	int awaiting;
	int results_seen;

	// stimulus knobs, some shared with the receiver process
	logic calm;
	logic squeeze_req;
	logic squeeze_done;
	int   cells_sent;
	int   cycle_count;

	grid_max_path_sum_counter #(
		.MAX_SIDE (MAX_SIDE)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cell_in     (cell_if),
		.result_out  (result_if)
	);

	// watches both channels and the config port, predicts every result
	gmps_path_checker #(
		.MAX_SIDE (MAX_SIDE)
	) u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cell_mon     (cell_if),
		.res_mon      (result_if),
		.pending      (awaiting),
		.errors       (mismatches),
		.results_seen (results_seen)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog: a hung handshake ends the run here
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("** grid_max_path_sum_counter: FAILED **");
			$finish;
		end
	end

	// idle length: mostly short, now and then long
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// sender gap after a request; none in calm stretches
	function automatic int pick_gap();
		if (calm)
			return 0;
		if ($urandom_range(0, 99) < 65)
			return 0;
		return idle_len();
	endfunction

	// receiver: random ready runs, one long hold-off on request, none when calm
	initial begin
		int run;
		result_if.ready <= 1'b0;
		squeeze_done = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (squeeze_req && !squeeze_done) begin
				// hold off while the sender keeps pushing, so the block backs up
				squeeze_done = 1'b1;
				result_if.ready <= 1'b0;
				for (int k = 0; k < HOLD_OFF_CYCLES; k++)
					@(posedge clk);
			end else if (calm) begin
				result_if.ready <= 1'b1;
				@(posedge clk);
			end else begin
				if ($urandom_range(0, 99) < 60) begin
					result_if.ready <= 1'b1;
					run = $urandom_range(1, 8);
				end else begin
					result_if.ready <= 1'b0;
					run = idle_len();
				end
				repeat (run) @(posedge clk);
			end
		end
	end

	// one cell request; returns right after the accepting edge (plus any gap)
	task automatic send_cell(input logic [DIGIT_W-1:0] digit, input logic blk);
		int gap;
		cell_if.valid      <= 1'b1;
		cell_if.cell_digit <= digit;
		cell_if.blocked    <= blk;
		@(posedge clk);
		while (!cell_if.ready)
			@(posedge clk);
		cells_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			cell_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid and wait until every predicted result has left the block,
	// then wait on so that a cell still in the merge stage has landed
	task automatic settle();
		cell_if.valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// side writes only while idle; each one restarts the grid
	task automatic write_side(input logic [CFG_W-1:0] side_val);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= side_val;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// a run of cells; a full grid when cells is side squared
	task automatic send_grid(input int cells, input digit_style_t style, input int block_pct);
		logic [DIGIT_W-1:0] d;
		for (int i = 0; i < cells; i++) begin
			case (style)
				STYLE_MIXED: begin
					// digits above nine now and then, they saturate at nine
					if ($urandom_range(0, 19) == 0)
						d = DIGIT_W'($urandom_range(10, 15));
					else
						d = DIGIT_W'($urandom_range(0, 9));
				end
				STYLE_FLAT: d = '0;
				STYLE_HIGH: d = DIGIT_W'($urandom_range(9, 15));
				default:    d = DIGIT_W'($urandom_range(0, 1));
			endcase
			send_cell(d, $urandom_range(0, 99) < block_pct);
		end
	endtask

	initial begin
		int           phase;
		int           n;
		int           grids;
		int           r;
		int           block_pct;
		logic         big;
		logic [7:0]   side_val;
		digit_style_t style;

		arst_n             <= 1'b0;
		cfg_wr_en          <= 1'b0;
		cfg_wr_data        <= '0;
		cell_if.valid      <= 1'b0;
		cell_if.cell_digit <= '0;
		cell_if.blocked    <= 1'b0;
		calm        = 1'b0;
		squeeze_req = 1'b0;
		cells_sent  = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed grids ---
		write_side(8'd2);
		// both middle cells blocked: only the diagonal step reaches the end;
		// flags and digits on start and end are ignored
		send_cell(4'd15, 1'b1);
		send_cell(4'd15, 1'b1);
		send_cell(4'd15, 1'b1);
		send_cell(4'd15, 1'b1);
		// all nines: two tied best paths
		send_cell(4'd9, 1'b0);
		send_cell(4'd9, 1'b0);
		send_cell(4'd9, 1'b0);
		send_cell(4'd9, 1'b0);

		// side zero clamps to two; one zero neighbour ties with the diagonal
		write_side(8'd0);
		send_cell(4'd0, 1'b0);
		send_cell(4'd0, 1'b0);
		send_cell(4'd7, 1'b1);
		send_cell(4'd0, 1'b1);

		// side one clamps to two; a twelve counts as nine
		write_side(8'd1);
		send_cell(4'd3, 1'b0);
		send_cell(4'd12, 1'b0);
		send_cell(4'd5, 1'b0);
		send_cell(4'd8, 1'b1);

		// side three, the whole middle row blocked: end unreachable
		write_side(8'd3);
		send_cell(4'd5, 1'b0);
		send_cell(4'd1, 1'b0);
		send_cell(4'd2, 1'b1);
		send_cell(4'd9, 1'b1);
		send_cell(4'd10, 1'b1);
		send_cell(4'd4, 1'b1);
		send_cell(4'd6, 1'b0);
		send_cell(4'd8, 1'b0);
		send_cell(4'd0, 1'b0);

		// --- random phases: one side setting each, mostly small grids ---
		phase = 0;
		while (cells_sent < ITEM_TARGET || results_seen < RESULT_TARGET
				|| phase <= LAST_BIG_PHASE) begin
			if (phase == 1) begin
				side_val = 8'd2;
			end else if (phase == LAST_BIG_PHASE) begin
				side_val = WRAP_SIDE;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 8)
					side_val = 8'($urandom_range(0, 1));
				else if (r < 85)
					side_val = 8'($urandom_range(2, 8));
				else
					side_val = 8'($urandom_range(9, 12));
			end
			write_side(side_val);
			n = (side_val < 2) ? 2 : ((side_val > MAX_SIDE) ? MAX_SIDE : side_val);
			big = (phase == LAST_BIG_PHASE);

			// the wrap grid and the squeeze phase run without idling
			calm = big || phase == 1 || $urandom_range(0, 4) == 0;
			grids = big ? 1 : ((phase == 1) ? 8 : $urandom_range(1, 3));
			if (phase == 1)
				squeeze_req = 1'b1;

			for (int g = 0; g < grids; g++) begin
				if (big) begin
					// flat zero grid: every path ties, counts wrap the modulus
					style     = STYLE_FLAT;
					block_pct = 3;
				end else begin
					style = digit_style_t'($urandom_range(0, 3));
					case ($urandom_range(0, 4))
						0:       block_pct = 0;
						1:       block_pct = 5;
						2:       block_pct = 15;
						3:       block_pct = 35;
						default: block_pct = 70;
					endcase
				end
				send_grid(n * n, style, block_pct);
				// sometimes the sender waits for every result before going on
				if (!big && $urandom_range(0, 3) == 0)
					settle();
			end

			// an unfinished grid, abandoned by the next side write
			if (!big && $urandom_range(0, 2) == 0)
				send_grid($urandom_range(1, n * n - 1), STYLE_MIXED, 10);
			phase++;
		end

		// drain, then allow for the block's tail
		calm = 1'b1;
		settle();
		repeat (8) @(posedge clk);

		if (mismatches == 0 && awaiting == 0)
			$display("** grid_max_path_sum_counter: PASSED **");
		else
			$display("** grid_max_path_sum_counter: FAILED **");
		$finish;
	end

endmodule
